### hw/rtl/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types, constants and codes of the grid ray traversal core.
// ----------------------------------------------------------------------------
package gtr_pkg;

    // screen and clip constants
    localparam int SCREEN_WIDTH = 320;
    localparam int HALF_WIDTH   = SCREEN_WIDTH / 2;
    localparam int NEAR_CLIP    = 256;

    // increment limits
    localparam logic [31:0] BIG_INC    = 32'd25600000;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
    localparam int          TINY_LIMIT = 26;

    // field widths
    localparam int COL_W   = 9;
    localparam int CELL_W  = 14;
    localparam int DIST_W  = 24;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 24;

    // datapath widths
    localparam int D_W     = 17;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 38;
    localparam int SQ_W    = 36;
    localparam int SQ_IN_W = SQ_W + 16;
    localparam int ROOT_W  = SQ_IN_W / 2;
    localparam int NUM_W   = ROOT_W + 14;
    localparam int DEN_W   = ACC_W - 1;
    localparam int CNT_W   = 6;

    // sequence lengths
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(6);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(2);

    // register indexes
    localparam logic [IDX_W-1:0] REG_CAM_X        = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAM_Y        = 3'd1;
    localparam logic [IDX_W-1:0] REG_HEADING_COS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEADING_SIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FOCAL_LENGTH = 3'd4;
    localparam logic [IDX_W-1:0] REG_WORLD_SIZE_X = 3'd5;
    localparam logic [IDX_W-1:0] REG_WORLD_SIZE_Y = 3'd6;
    localparam logic [IDX_W-1:0] REG_CLIP_FAR     = 3'd7;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic signed [20:0] cam_x;
        logic signed [20:0] cam_y;
        logic signed [15:0] heading_cos;
        logic signed [15:0] heading_sin;
        logic [15:0]        focal_length;
        logic [12:0]        world_size_x;
        logic [12:0]        world_size_y;
        logic [23:0]        clip_far;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_DIVX,
        S_DIVY,
        S_SEED,
        S_WALK,
        S_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_ADV,
        OP_MUL,
        OP_SQRT,
        OP_DIVX,
        OP_DIVY,
        OP_SEED,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_more;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/gtr_if.sv
// ----------------------------------------------------------------------------
// gtr_if
// Valid/ready channels of the grid ray traversal core.
// ----------------------------------------------------------------------------
interface gtr_req_if;
    import gtr_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [COL_W-1:0] column;
    modport source (output valid, output command, output column, input ready);
    modport sink   (input valid, input command, input column, output ready);
endinterface

interface gtr_rsp_if;
    import gtr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_y;
    logic [DIST_W-1:0]        distance;
    logic                     crossed_x_side;
    logic                     in_range;
    modport source (output valid, output cell_x, output cell_y, output distance,
                    output crossed_x_side, output in_range, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input distance,
                    input crossed_x_side, input in_range, output ready);
endinterface

interface gtr_cfg_if;
    import gtr_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/gtr_cfg_regs.sv
// ----------------------------------------------------------------------------
// gtr_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module gtr_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_valid,
    input  logic [gtr_pkg::IDX_W-1:0] wr_index,
    input  logic [gtr_pkg::DATA_W-1:0] wr_data,
    output logic                      wr_ready,
    output gtr_pkg::cfg_regs_t        cfg
);
    import gtr_pkg::*;

    cfg_regs_t cfg_reg;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x        <= '0;
            cfg_reg.cam_y        <= '0;
            cfg_reg.heading_cos  <= 16'sd16384;
            cfg_reg.heading_sin  <= '0;
            cfg_reg.focal_length <= 16'd2560;
            cfg_reg.world_size_x <= 13'd512;
            cfg_reg.world_size_y <= 13'd512;
            cfg_reg.clip_far     <= 24'd512000;
        end
        else if (wr_valid)
        begin
            case (wr_index)
                REG_CAM_X:        cfg_reg.cam_x        <= wr_data[20:0];
                REG_CAM_Y:        cfg_reg.cam_y        <= wr_data[20:0];
                REG_HEADING_COS:  cfg_reg.heading_cos  <= wr_data[15:0];
                REG_HEADING_SIN:  cfg_reg.heading_sin  <= wr_data[15:0];
                REG_FOCAL_LENGTH: cfg_reg.focal_length <= wr_data[15:0];
                REG_WORLD_SIZE_X: cfg_reg.world_size_x <= wr_data[12:0];
                REG_WORLD_SIZE_Y: cfg_reg.world_size_y <= wr_data[12:0];
                REG_CLIP_FAR:     cfg_reg.clip_far     <= wr_data[23:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

endmodule

### hw/rtl/gtr_ctrl.sv
// ----------------------------------------------------------------------------
// gtr_ctrl
// Sequencer: walks a start through multiply, root, divide, seed and near
// clip phases, and a step through one crossing, then hands off the result.
// ----------------------------------------------------------------------------
module gtr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_command,
    output logic               req_ready,
    input  gtr_pkg::dp_stat_t  stat,
    output gtr_pkg::dp_cmd_t   cmd
);
    import gtr_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (req_valid)
                begin
                    state_next = (req_command == CMD_START) ? S_MUL : S_FIN;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_DIVX;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIVX:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIVY;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIVY:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SEED;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SEED:
            begin
                if (cnt_reg == SEED_LAST)
                begin
                    state_next = S_WALK;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WALK:
            begin
                if (!stat.walk_more)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.cnt   = cnt_reg;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = (req_command == CMD_START) ? OP_START : OP_ADV;
                end
            end
            S_MUL:  cmd.op = OP_MUL;
            S_SQRT: cmd.op = OP_SQRT;
            S_DIVX: cmd.op = OP_DIVX;
            S_DIVY: cmd.op = OP_DIVY;
            S_SEED: cmd.op = OP_SEED;
            S_WALK: cmd.op = stat.walk_more ? OP_ADV : OP_NONE;
            S_FIN:  cmd.op = stat.out_free ? OP_OUT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

### hw/rtl/gtr_datapath.sv
// ----------------------------------------------------------------------------
// gtr_datapath
// Ray state, shared multiplier, bit-serial root and divider, seeding,
// crossing logic and the result register.
// ----------------------------------------------------------------------------
module gtr_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gtr_pkg::dp_cmd_t                 cmd,
    output gtr_pkg::dp_stat_t                stat,
    input  gtr_pkg::cfg_regs_t               cfg,
    input  logic [gtr_pkg::COL_W-1:0]        req_column,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic signed [gtr_pkg::CELL_W-1:0] res_cell_x,
    output logic signed [gtr_pkg::CELL_W-1:0] res_cell_y,
    output logic [gtr_pkg::DIST_W-1:0]       res_distance,
    output logic                             res_crossed_x_side,
    output logic                             res_in_range
);
    import gtr_pkg::*;

    // start working registers
    logic [COL_W-1:0]         col_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  tx_reg, ty_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_IN_W-1:0]       sqx_reg;
    logic [ROOT_W+1:0]        sqrem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [NUM_W-1:0]         num_reg, quo_reg;
    logic [DEN_W-1:0]         den_reg, rem_reg;
    logic [40:0]              seed_prod_reg;

    // ray state
    logic signed [CELL_W-1:0] cell_x_reg, cell_y_reg;
    logic                     pos_x_reg, neg_x_reg, pos_y_reg, neg_y_reg;
    logic [31:0]              delta_x_reg, delta_y_reg;
    logic [31:0]              nx_reg, ny_reg, dist_reg;
    logic                     last_x_reg;

    // result register
    logic                     res_valid_reg;
    logic signed [CELL_W-1:0] res_cell_x_reg, res_cell_y_reg;
    logic [DIST_W-1:0]        res_distance_reg;
    logic                     res_side_reg, res_in_range_reg;

    // column offset with 4 fraction bits
    logic signed [D_W-1:0] d_base, d_val;
    assign d_base = $signed({{(D_W-COL_W-1){1'b0}}, col_reg, 1'b1})
                    - $signed(D_W'(2 * HALF_WIDTH));
    assign d_val  = d_base <<< 3;

    // shared multiplier operands
    logic signed [MUL_W-1:0]  f18, d18, cs18, sn18, mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;
    assign f18  = $signed({2'b00, cfg.focal_length});
    assign d18  = MUL_W'(d_val);
    assign cs18 = MUL_W'(cfg.heading_cos);
    assign sn18 = MUL_W'(cfg.heading_sin);

    always_comb
    begin
        case (cmd.cnt[2:0])
            3'd0:    begin mul_a = d18; mul_b = cs18; end
            3'd1:    begin mul_a = f18; mul_b = sn18; end
            3'd2:    begin mul_a = d18; mul_b = sn18; end
            3'd3:    begin mul_a = f18; mul_b = cs18; end
            3'd4:    begin mul_a = f18; mul_b = f18;  end
            default: begin mul_a = d18; mul_b = d18;  end
        endcase
    end
    assign prod_next = mul_a * mul_b;

    // root step, two input bits per cycle
    logic [SQ_IN_W-1:0] sqx_cur;
    logic [ROOT_W+1:0]  sqrem_cur, sqrem_sh, sq_trial;
    logic [ROOT_W-1:0]  root_cur;
    assign sqx_cur   = (cmd.cnt == '0) ? {sq_reg, 16'd0} : sqx_reg;
    assign sqrem_cur = (cmd.cnt == '0) ? '0 : sqrem_reg;
    assign root_cur  = (cmd.cnt == '0) ? '0 : root_reg;
    assign sqrem_sh  = {sqrem_cur[ROOT_W-1:0], sqx_cur[SQ_IN_W-1 -: 2]};
    assign sq_trial  = {root_cur, 2'b01};

    // magnitudes of the direction
    logic [DEN_W-1:0] abs_tx, abs_ty;
    logic signed [ACC_W-1:0] neg_tx, neg_ty;
    assign neg_tx = -tx_reg;
    assign neg_ty = -ty_reg;
    assign abs_tx = tx_reg[ACC_W-1] ? neg_tx[DEN_W-1:0] : tx_reg[DEN_W-1:0];
    assign abs_ty = ty_reg[ACC_W-1] ? neg_ty[DEN_W-1:0] : ty_reg[DEN_W-1:0];

    // restoring divider step, one quotient bit per cycle
    logic             div_first;
    logic [NUM_W-1:0] num_cur, quo_cur, quo_next;
    logic [DEN_W-1:0] den_cur, rem_cur;
    logic [DEN_W:0]   rem_sh, rem_diff;
    logic             q_bit;
    logic [31:0]      inc_val;
    assign div_first = (cmd.cnt == '0);
    assign num_cur   = div_first ? {root_reg, 14'd0} : num_reg;
    assign quo_cur   = div_first ? '0 : quo_reg;
    assign rem_cur   = div_first ? '0 : rem_reg;
    assign den_cur   = div_first ? ((cmd.op == OP_DIVX) ? abs_tx : abs_ty) : den_reg;
    assign rem_sh    = {rem_cur, num_cur[NUM_W-1]};
    assign q_bit     = (rem_sh >= {1'b0, den_cur});
    assign rem_diff  = rem_sh - {1'b0, den_cur};
    assign quo_next  = {quo_cur[NUM_W-2:0], q_bit};

    // increment with tiny-direction and range limits
    always_comb
    begin
        if (den_cur <= DEN_W'(TINY_LIMIT))
        begin
            inc_val = BIG_INC;
        end
        else if (quo_next[NUM_W-1:32] != '0)
        begin
            inc_val = SAT32;
        end
        else if (quo_next[31:0] == 32'd0)
        begin
            inc_val = 32'd1;
        end
        else
        begin
            inc_val = quo_next[31:0];
        end
    end

    // first crossing seeds
    logic       tx_pos, ty_pos, tx_neg, ty_neg;
    logic [8:0] kx, ky;
    logic [40:0] seed_prod_next;
    logic [31:0] seed_val;
    assign tx_neg = tx_reg[ACC_W-1];
    assign ty_neg = ty_reg[ACC_W-1];
    assign tx_pos = !tx_neg && (tx_reg != '0);
    assign ty_pos = !ty_neg && (ty_reg != '0);
    assign kx = tx_pos ? (9'd256 - {1'b0, cfg.cam_x[7:0]}) : {1'b0, cfg.cam_x[7:0]};
    assign ky = ty_pos ? (9'd256 - {1'b0, cfg.cam_y[7:0]}) : {1'b0, cfg.cam_y[7:0]};
    assign seed_prod_next = (cmd.cnt == '0) ? ({32'd0, kx} * {9'd0, delta_x_reg})
                                             : ({32'd0, ky} * {9'd0, delta_y_reg});
    assign seed_val = (seed_prod_reg[40] == 1'b1) ? SAT32 : seed_prod_reg[39:8];

    // crossing of the nearer boundary
    logic        take_x;
    logic [32:0] sum_x, sum_y;
    logic signed [CELL_W:0] cx_sum, cy_sum;
    logic signed [CELL_W-1:0] cx_new, cy_new;
    assign take_x = (nx_reg < ny_reg);
    assign sum_x  = {1'b0, nx_reg} + {1'b0, delta_x_reg};
    assign sum_y  = {1'b0, ny_reg} + {1'b0, delta_y_reg};
    assign cx_sum = {cell_x_reg[CELL_W-1], cell_x_reg}
                    + (pos_x_reg ? (CELL_W+1)'(1) : (neg_x_reg ? '1 : '0));
    assign cy_sum = {cell_y_reg[CELL_W-1], cell_y_reg}
                    + (pos_y_reg ? (CELL_W+1)'(1) : (neg_y_reg ? '1 : '0));
    assign cx_new = (cx_sum[CELL_W] != cx_sum[CELL_W-1])
                    ? (cx_sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}})
                    : cx_sum[CELL_W-1:0];
    assign cy_new = (cy_sum[CELL_W] != cy_sum[CELL_W-1])
                    ? (cy_sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}})
                    : cy_sum[CELL_W-1:0];

    // range check of the current state
    logic in_range_now;
    logic signed [CELL_W:0] cx_ext, cy_ext, wsx_ext, wsy_ext;
    assign cx_ext  = {cell_x_reg[CELL_W-1], cell_x_reg};
    assign cy_ext  = {cell_y_reg[CELL_W-1], cell_y_reg};
    assign wsx_ext = $signed({2'b00, cfg.world_size_x});
    assign wsy_ext = $signed({2'b00, cfg.world_size_y});
    always_comb
    begin
        in_range_now = 1'b1;
        if (pos_x_reg && (cx_ext > wsx_ext))         in_range_now = 1'b0;
        if (neg_x_reg && cell_x_reg[CELL_W-1])       in_range_now = 1'b0;
        if (pos_y_reg && (cy_ext > wsy_ext))         in_range_now = 1'b0;
        if (neg_y_reg && cell_y_reg[CELL_W-1])       in_range_now = 1'b0;
        if (dist_reg > {8'd0, cfg.clip_far})         in_range_now = 1'b0;
    end

    // status to the sequencer
    assign stat.walk_more = (nx_reg < 32'(NEAR_CLIP)) || (ny_reg < 32'(NEAR_CLIP));
    assign stat.out_free  = !res_valid_reg || res_ready;

    // start working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                col_reg <= req_column;
            end
            OP_MUL:
            begin
                if (cmd.cnt != MUL_LAST)
                begin
                    prod_reg <= prod_next;
                end
                case (cmd.cnt[2:0])
                    3'd1:    tx_reg <= ACC_W'(prod_reg);
                    3'd2:    tx_reg <= tx_reg + ACC_W'(prod_reg);
                    3'd3:    ty_reg <= -ACC_W'(prod_reg);
                    3'd4:    ty_reg <= ty_reg + ACC_W'(prod_reg);
                    3'd5:    sq_reg <= SQ_W'(prod_reg);
                    3'd6:    sq_reg <= sq_reg + SQ_W'(prod_reg);
                    default: sq_reg <= sq_reg;
                endcase
            end
            OP_SQRT:
            begin
                sqx_reg <= sqx_cur << 2;
                if (sqrem_sh >= sq_trial)
                begin
                    sqrem_reg <= sqrem_sh - sq_trial;
                    root_reg  <= {root_cur[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sqrem_reg <= sqrem_sh;
                    root_reg  <= {root_cur[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DIVX, OP_DIVY:
            begin
                num_reg <= num_cur << 1;
                quo_reg <= quo_next;
                den_reg <= den_cur;
                rem_reg <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            end
            OP_SEED:
            begin
                seed_prod_reg <= seed_prod_next;
            end
            default:
            begin
                col_reg <= col_reg;
            end
        endcase
    end

    // ray state, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_x_reg  <= '0;
            cell_y_reg  <= '0;
            pos_x_reg   <= 1'b0;
            neg_x_reg   <= 1'b0;
            pos_y_reg   <= 1'b0;
            neg_y_reg   <= 1'b0;
            delta_x_reg <= '0;
            delta_y_reg <= '0;
            nx_reg      <= '0;
            ny_reg      <= '0;
            dist_reg    <= '0;
            last_x_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_DIVX:
                begin
                    if (cmd.cnt == DIV_LAST)
                    begin
                        delta_x_reg <= inc_val;
                    end
                end
                OP_DIVY:
                begin
                    if (cmd.cnt == DIV_LAST)
                    begin
                        delta_y_reg <= inc_val;
                    end
                end
                OP_SEED:
                begin
                    case (cmd.cnt[1:0])
                        2'd0:
                        begin
                            pos_x_reg  <= tx_pos;
                            neg_x_reg  <= tx_neg;
                            pos_y_reg  <= ty_pos;
                            neg_y_reg  <= ty_neg;
                            cell_x_reg <= CELL_W'(cfg.cam_x >>> 8);
                            cell_y_reg <= CELL_W'(cfg.cam_y >>> 8);
                        end
                        2'd1:
                        begin
                            nx_reg <= seed_val;
                        end
                        default:
                        begin
                            ny_reg     <= seed_val;
                            dist_reg   <= '0;
                            last_x_reg <= 1'b0;
                        end
                    endcase
                end
                OP_ADV:
                begin
                    if (take_x)
                    begin
                        cell_x_reg <= cx_new;
                        dist_reg   <= nx_reg;
                        nx_reg     <= sum_x[32] ? SAT32 : sum_x[31:0];
                        last_x_reg <= 1'b1;
                    end
                    else
                    begin
                        cell_y_reg <= cy_new;
                        dist_reg   <= ny_reg;
                        ny_reg     <= sum_y[32] ? SAT32 : sum_y[31:0];
                        last_x_reg <= 1'b0;
                    end
                end
                default:
                begin
                    dist_reg <= dist_reg;
                end
            endcase
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            res_cell_x_reg   <= cell_x_reg;
            res_cell_y_reg   <= cell_y_reg;
            res_distance_reg <= (dist_reg[31:24] != '0) ? '1 : dist_reg[23:0];
            res_side_reg     <= last_x_reg;
            res_in_range_reg <= in_range_now;
        end
    end

    assign res_valid          = res_valid_reg;
    assign res_cell_x         = res_cell_x_reg;
    assign res_cell_y         = res_cell_y_reg;
    assign res_distance       = res_distance_reg;
    assign res_crossed_x_side = res_side_reg;
    assign res_in_range       = res_in_range_reg;

endmodule

### hw/rtl/grid_ray_traversal_core.sv
// ----------------------------------------------------------------------------
// grid_ray_traversal_core
// 2D grid ray stepper for one screen column.
// ----------------------------------------------------------------------------
// req carries one item per command: command 0 starts the ray of a column,
// command 1 crosses the nearer x or y cell boundary. Every item gives one
// item on rsp: cell, distance, side crossed and in-range flag.
// cfg writes the eight registers by index; it is always ready and should
// only be used while the core is idle.
// A step is crossed at its accept edge; the S_FIN state then loads the
// result register once rsp is free, which makes its item valid, and the core
// returns to idle, where the next item is taken. A start runs, in order, the
// multiply steps on the shared multiplier, the two-bits-a-cycle root, the x
// and y passes of the bit-serial divider, the seed steps, a walk step for
// each near clip crossing and a last one that only finds that nothing lies
// nearer than the near clip, and the result load.
// One item is in flight at a time; req is ready only when the core is idle.
// A stalled rsp holds its item; the core then waits with the next result.
// Reset loads the register defaults and clears the ray state to zero.
// ----------------------------------------------------------------------------
module grid_ray_traversal_core (
    input logic         clk,
    input logic         rst_n,
    gtr_req_if.sink     req,
    gtr_rsp_if.source   rsp,
    gtr_cfg_if.sink     cfg
);
    import gtr_pkg::*;

    cfg_regs_t cfg_regs;
    dp_cmd_t   cmd;
    dp_stat_t  stat;

    // configuration registers
    gtr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .wr_ready (cfg.ready),
        .cfg      (cfg_regs)
    );

    // sequencer
    gtr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // datapath
    gtr_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg                (cfg_regs),
        .req_column         (req.column),
        .res_valid          (rsp.valid),
        .res_ready          (rsp.ready),
        .res_cell_x         (rsp.cell_x),
        .res_cell_y         (rsp.cell_y),
        .res_distance       (rsp.distance),
        .res_crossed_x_side (rsp.crossed_x_side),
        .res_in_range       (rsp.in_range)
    );

endmodule

### hw/rtl/gtr_checker.sv
// ----------------------------------------------------------------------------
// gtr_checker
// Port-level checks of the grid ray traversal core.
// ----------------------------------------------------------------------------
module gtr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [23:0] rsp_distance,
    input logic [13:0] rsp_cell_x,
    input logic [13:0] rsp_cell_y
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
        && $stable(rsp_cell_x) && $stable(rsp_cell_y))
        else $error("stalled result changed");

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("accept right after accept");

    // a new result appears only after the core was busy
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result without work");

endmodule

bind grid_ray_traversal_core gtr_checker u_gtr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_distance (rsp.distance),
    .rsp_cell_x   (rsp.cell_x),
    .rsp_cell_y   (rsp.cell_y)
);
